### hdl/srcs_pkg.sv
// Shared types and constants for the simple RISC core step unit.
package srcs_pkg;

	localparam int MEM_WORDS_DEF = 4096;
	localparam int IO_REG_COUNT  = 18;
	localparam int REG_COUNT     = 16;

	// item modes
	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_STEP = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	// io access kinds
	localparam logic [1:0] IOA_NONE  = 2'd0;
	localparam logic [1:0] IOA_READ  = 2'd1;
	localparam logic [1:0] IOA_WRITE = 2'd2;

	// opcodes
	localparam logic [7:0] OP_ADD  = 8'd0;
	localparam logic [7:0] OP_SUB  = 8'd1;
	localparam logic [7:0] OP_AND  = 8'd2;
	localparam logic [7:0] OP_OR   = 8'd3;
	localparam logic [7:0] OP_SLL  = 8'd4;
	localparam logic [7:0] OP_SRA  = 8'd5;
	localparam logic [7:0] OP_SRL  = 8'd6;
	localparam logic [7:0] OP_BEQ  = 8'd7;
	localparam logic [7:0] OP_BNE  = 8'd8;
	localparam logic [7:0] OP_BLT  = 8'd9;
	localparam logic [7:0] OP_BGT  = 8'd10;
	localparam logic [7:0] OP_BLE  = 8'd11;
	localparam logic [7:0] OP_BGE  = 8'd12;
	localparam logic [7:0] OP_JAL  = 8'd13;
	localparam logic [7:0] OP_LW   = 8'd14;
	localparam logic [7:0] OP_SW   = 8'd15;
	localparam logic [7:0] OP_RETI = 8'd16;
	localparam logic [7:0] OP_IN   = 8'd17;
	localparam logic [7:0] OP_OUT  = 8'd18;
	localparam logic [7:0] OP_HALT = 8'd19;

	// io register numbers
	localparam logic [4:0] IO_IRQ0EN    = 5'd0;
	localparam logic [4:0] IO_IRQ1EN    = 5'd1;
	localparam logic [4:0] IO_IRQ2EN    = 5'd2;
	localparam logic [4:0] IO_IRQ0ST    = 5'd3;
	localparam logic [4:0] IO_IRQ1ST    = 5'd4;
	localparam logic [4:0] IO_IRQ2ST    = 5'd5;
	localparam logic [4:0] IO_IRQHANDLER = 5'd6;
	localparam logic [4:0] IO_IRQRETURN = 5'd7;
	localparam logic [4:0] IO_CLKS      = 5'd8;
	localparam logic [4:0] IO_TIMEREN   = 5'd11;
	localparam logic [4:0] IO_TIMERCUR  = 5'd12;
	localparam logic [4:0] IO_TIMERMAX  = 5'd13;

	localparam logic [3:0] REG_RA = 4'd15;

	typedef struct packed {
		logic accept;
		logic clear;
		logic fetch;
		logic rd_rs;
		logic rd_rt;
		logic rd_rd;
		logic exec;
		logic memw;
		logic rdw;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic fetch_stop;
		logic exec_lw;
	} sts_t;

endpackage

### hdl/srcs_ram.sv
// Generic single write, single read RAM with registered read data.
module srcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/srcs_ctrl.sv
// Controller state machine of the step unit.
module srcs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     mode,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  srcs_pkg::sts_t sts,
	output srcs_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_FETCH = 4'd2;
	localparam logic [3:0] ST_RS    = 4'd3;
	localparam logic [3:0] ST_RT    = 4'd4;
	localparam logic [3:0] ST_RD    = 4'd5;
	localparam logic [3:0] ST_EXEC  = 4'd6;
	localparam logic [3:0] ST_MEMW  = 4'd7;
	localparam logic [3:0] ST_RDW   = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	logic [3:0] state_q, state_nx;
	logic       out_valid_q;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (mode)
						srcs_pkg::MODE_STEP: state_nx = ST_FETCH;
						srcs_pkg::MODE_READ: state_nx = ST_RDW;
						default:             state_nx = ST_DONE;
					endcase
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_nx  = sts.fetch_stop ? ST_DONE : ST_RS;
			end
			ST_RS: begin
				cmd.rd_rs = 1'b1;
				state_nx  = ST_RT;
			end
			ST_RT: begin
				cmd.rd_rt = 1'b1;
				state_nx  = ST_RD;
			end
			ST_RD: begin
				cmd.rd_rd = 1'b1;
				state_nx  = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_nx = sts.exec_lw ? ST_MEMW : ST_DONE;
			end
			ST_MEMW: begin
				cmd.memw = 1'b1;
				state_nx = ST_DONE;
			end
			ST_RDW: begin
				cmd.rdw  = 1'b1;
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_nx    = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_stop_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH && sts.fetch_stop) |=> (state_q == ST_DONE))
		else $error("halted or halting step did not skip execution");

	a_lw_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && sts.exec_lw) |=> (state_q == ST_MEMW))
		else $error("load word skipped its memory wait");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !out_ready) |=> (state_q == ST_DONE))
		else $error("result published over a pending one");

endmodule

### hdl/srcs_dp.sv
// Datapath of the step unit: memories, register file, io registers, ALU.
module srcs_dp #(
	parameter int MEM_WORDS = srcs_pkg::MEM_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  srcs_pkg::cmd_t cmd,
	output srcs_pkg::sts_t sts,
	input  logic [1:0]     mode,
	input  logic [11:0]    address,
	input  logic [31:0]    data,
	output logic [11:0]    step_pc,
	output logic [31:0]    step_instruction,
	output logic           halted,
	output logic           irq_taken,
	output logic [1:0]     io_access,
	output logic [4:0]     io_index,
	output logic [31:0]    io_value,
	output logic [31:0]    cycle_count,
	output logic [31:0]    read_word
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam int RN = srcs_pkg::REG_COUNT;
	localparam int RW = $clog2(RN);
	localparam int IN = srcs_pkg::IO_REG_COUNT;

	function automatic logic [AW-1:0] mem_idx(input logic [11:0] a);
		logic [13:0] t;
		begin
			t = {2'b00, a};
			if (t >= 14'(3 * MEM_WORDS)) t = t - 14'(3 * MEM_WORDS);
			else if (t >= 14'(2 * MEM_WORDS)) t = t - 14'(2 * MEM_WORDS);
			else if (t >= 14'(MEM_WORDS)) t = t - 14'(MEM_WORDS);
			return t[AW-1:0];
		end
	endfunction

	// architectural state
	logic [11:0] pc_q;
	logic        halt_q, inh_q;
	logic [31:0] io_q  [IN];
	logic [31:0] io_nx [IN];
	logic [RN-1:0] rf_valid_q;
	logic [AW-1:0] clr_q;

	// per-item work registers
	logic [31:0] inst_q, a_q, b_q, d_q;
	logic [RW-1:0] ridx_q;

	// result registers
	logic [11:0] res_pc_q;
	logic [31:0] res_inst_q, res_ioval_q, res_clk_q, res_rdw_q;
	logic        res_irq_q;
	logic [1:0]  res_ioacc_q;
	logic [4:0]  res_ioidx_q;

	// memory ports
	logic          m_we;
	logic [AW-1:0] m_waddr, m_raddr;
	logic [31:0]   m_wdata, m_rdata;

	logic          rf_we;
	logic [RW-1:0] rf_waddr, rf_raddr;
	logic [31:0]   rf_wdata, rf_rdata, rf_val;

	// decode
	logic [7:0]    op;
	logic [RW-1:0] f_rd;
	logic [31:0]   imm, sum;
	logic [4:0]    sh;
	logic          irq_take, io_ok, br_take, w_alu;
	logic [31:0]   alu;
	logic [11:0]   pc_inc, next_pc;

	assign op   = inst_q[31:24];
	assign f_rd = inst_q[23:20];
	assign imm  = {{20{inst_q[11]}}, inst_q[11:0]};
	assign sum  = a_q + b_q;
	assign sh   = b_q[4:0];
	assign pc_inc = pc_q + 12'd1;
	assign io_ok  = sum < 32'(IN);

	assign irq_take = !inh_q && (
		(io_q[srcs_pkg::IO_IRQ0EN] != 32'd0 && io_q[srcs_pkg::IO_IRQ0ST] != 32'd0) ||
		(io_q[srcs_pkg::IO_IRQ1EN] != 32'd0 && io_q[srcs_pkg::IO_IRQ1ST] != 32'd0) ||
		(io_q[srcs_pkg::IO_IRQ2EN] != 32'd0 && io_q[srcs_pkg::IO_IRQ2ST] != 32'd0));

	// r0 reads zero, r1 holds the current immediate, unwritten registers read zero
	always_comb begin
		if (ridx_q == RW'(0)) rf_val = 32'd0;
		else if (ridx_q == RW'(1)) rf_val = imm;
		else if (rf_valid_q[ridx_q]) rf_val = rf_rdata;
		else rf_val = 32'd0;
	end

	always_comb begin
		alu   = 32'd0;
		w_alu = 1'b0;
		br_take = 1'b0;
		case (op)
			srcs_pkg::OP_ADD: begin alu = a_q + b_q; w_alu = 1'b1; end
			srcs_pkg::OP_SUB: begin alu = a_q - b_q; w_alu = 1'b1; end
			srcs_pkg::OP_AND: begin alu = a_q & b_q; w_alu = 1'b1; end
			srcs_pkg::OP_OR:  begin alu = a_q | b_q; w_alu = 1'b1; end
			srcs_pkg::OP_SLL: begin alu = a_q << sh; w_alu = 1'b1; end
			srcs_pkg::OP_SRA: begin alu = $unsigned($signed(a_q) >>> sh); w_alu = 1'b1; end
			srcs_pkg::OP_SRL: begin alu = a_q >> sh; w_alu = 1'b1; end
			srcs_pkg::OP_BEQ: br_take = (a_q == b_q);
			srcs_pkg::OP_BNE: br_take = (a_q != b_q);
			srcs_pkg::OP_BLT: br_take = $signed(a_q) < $signed(b_q);
			srcs_pkg::OP_BGT: br_take = $signed(b_q) < $signed(a_q);
			srcs_pkg::OP_BLE: br_take = !($signed(b_q) < $signed(a_q));
			srcs_pkg::OP_BGE: br_take = !($signed(a_q) < $signed(b_q));
			srcs_pkg::OP_IN: begin
				alu   = io_ok ? io_q[sum[4:0]] : 32'd0;
				w_alu = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		next_pc = pc_inc;
		if (irq_take) next_pc = io_q[srcs_pkg::IO_IRQHANDLER][11:0];
		else if (br_take) next_pc = d_q[11:0];
		else if (op == srcs_pkg::OP_JAL) next_pc = (f_rd == srcs_pkg::REG_RA) ? pc_inc : d_q[11:0];
		else if (op == srcs_pkg::OP_RETI) next_pc = io_q[srcs_pkg::IO_IRQRETURN][11:0];
	end

	// io register update for one executed step: access, then timer, then clock
	always_comb begin
		for (int i = 0; i < IN; i++) io_nx[i] = io_q[i];
		if (irq_take) io_nx[srcs_pkg::IO_IRQRETURN] = {20'd0, pc_q};
		else if (op == srcs_pkg::OP_OUT && io_ok) io_nx[sum[4:0]] = d_q;
		if (io_nx[srcs_pkg::IO_TIMEREN] == 32'd1) begin
			if (io_nx[srcs_pkg::IO_TIMERCUR] != io_nx[srcs_pkg::IO_TIMERMAX]) begin
				io_nx[srcs_pkg::IO_TIMERCUR] = io_nx[srcs_pkg::IO_TIMERCUR] + 32'd1;
			end else begin
				io_nx[srcs_pkg::IO_IRQ0ST]   = 32'd1;
				io_nx[srcs_pkg::IO_TIMERCUR] = 32'd0;
			end
		end
		io_nx[srcs_pkg::IO_CLKS] = io_nx[srcs_pkg::IO_CLKS] + 32'd1;
	end

	// main memory ports
	always_comb begin
		m_we    = 1'b0;
		m_waddr = clr_q;
		m_wdata = 32'd0;
		if (cmd.clear) begin
			m_we = 1'b1;
		end else if (cmd.accept && mode == srcs_pkg::MODE_LOAD) begin
			m_we    = 1'b1;
			m_waddr = mem_idx(address);
			m_wdata = data;
		end else if (cmd.exec && !irq_take && op == srcs_pkg::OP_SW) begin
			m_we    = 1'b1;
			m_waddr = mem_idx(sum[11:0]);
			m_wdata = d_q;
		end
		if (cmd.accept) m_raddr = (mode == srcs_pkg::MODE_STEP) ? mem_idx(pc_q) : mem_idx(address);
		else m_raddr = mem_idx(sum[11:0]);
	end

	// register file ports
	always_comb begin
		if (cmd.fetch) rf_raddr = m_rdata[19:16];
		else if (cmd.rd_rs) rf_raddr = inst_q[15:12];
		else rf_raddr = f_rd;
		rf_we    = 1'b0;
		rf_waddr = f_rd;
		rf_wdata = alu;
		if (cmd.exec && !irq_take) begin
			if (op == srcs_pkg::OP_JAL) begin
				rf_we    = 1'b1;
				rf_waddr = srcs_pkg::REG_RA;
				rf_wdata = {20'd0, pc_inc};
			end else begin
				rf_we = w_alu && (f_rd > RW'(1));
			end
		end else if (cmd.memw) begin
			rf_we    = f_rd > RW'(1);
			rf_wdata = m_rdata;
		end
	end

	srcs_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	srcs_ram #(.WIDTH(32), .DEPTH(RN)) u_rf (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rf_raddr), .rdata(rf_rdata)
	);

	assign sts.clear_last = (clr_q == AW'(MEM_WORDS - 1));
	assign sts.fetch_stop = halt_q || (m_rdata[31:24] == srcs_pkg::OP_HALT);
	assign sts.exec_lw    = !irq_take && (op == srcs_pkg::OP_LW);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= 12'd0;
			halt_q     <= 1'b0;
			inh_q      <= 1'b0;
			rf_valid_q <= '0;
			clr_q      <= '0;
			for (int i = 0; i < IN; i++) io_q[i] <= 32'd0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + AW'(1);
			if (rf_we) rf_valid_q[rf_waddr] <= 1'b1;
			if (cmd.fetch && !halt_q && m_rdata[31:24] == srcs_pkg::OP_HALT) halt_q <= 1'b1;
			if (cmd.exec) begin
				pc_q <= next_pc;
				if (irq_take) inh_q <= 1'b1;
				else if (op == srcs_pkg::OP_RETI) inh_q <= 1'b0;
				for (int i = 0; i < IN; i++) io_q[i] <= io_nx[i];
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		ridx_q <= rf_raddr;
		if (cmd.accept) begin
			res_pc_q    <= (mode == srcs_pkg::MODE_STEP) ? pc_q : 12'd0;
			res_inst_q  <= 32'd0;
			res_irq_q   <= 1'b0;
			res_ioacc_q <= srcs_pkg::IOA_NONE;
			res_ioidx_q <= 5'd0;
			res_ioval_q <= 32'd0;
			res_clk_q   <= io_q[srcs_pkg::IO_CLKS];
			res_rdw_q   <= 32'd0;
		end
		if (cmd.fetch) begin
			inst_q     <= m_rdata;
			res_inst_q <= m_rdata;
		end
		if (cmd.rd_rs) a_q <= rf_val;
		if (cmd.rd_rt) b_q <= rf_val;
		if (cmd.rd_rd) d_q <= rf_val;
		if (cmd.rdw) res_rdw_q <= m_rdata;
		if (cmd.exec) begin
			res_irq_q <= irq_take;
			if (!irq_take && io_ok && op == srcs_pkg::OP_IN) begin
				res_ioacc_q <= srcs_pkg::IOA_READ;
				res_ioidx_q <= sum[4:0];
				res_ioval_q <= alu;
			end else if (!irq_take && io_ok && op == srcs_pkg::OP_OUT) begin
				res_ioacc_q <= srcs_pkg::IOA_WRITE;
				res_ioidx_q <= sum[4:0];
				res_ioval_q <= d_q;
			end
		end
		if (cmd.publish) begin
			step_pc          <= res_pc_q;
			step_instruction <= res_inst_q;
			halted           <= halt_q;
			irq_taken        <= res_irq_q;
			io_access        <= res_ioacc_q;
			io_index         <= res_ioidx_q;
			io_value         <= res_ioval_q;
			cycle_count      <= res_clk_q;
			read_word        <= res_rdw_q;
		end
	end

endmodule

### hdl/simple_risc_core_step_unit.sv
// Top level of the simple RISC core step unit.
//
// Input channel (in_valid/in_ready) carries one item: mode, address, data.
//   mode 0 stores data at memory word address, mode 2 reads that word,
//   mode 1 runs one instruction step of the core, mode 3 does nothing.
// Output channel (out_valid/out_ready) returns exactly one result item per
//   input item, in order, held in an output register until taken.
// A load or mode 3 item goes straight to the result; a read does one memory
//   read; a halted or halting step stops after its fetch. A normal step, set by
//   the registered-read memories, does a fetch, then three reads of the single
//   read port of the register file (rs, rt, rd), an execute step and, for lw,
//   one data memory read.
// One item is in work at a time; the next can be taken the cycle after the
//   previous result is placed in the output register, which may still wait.
// If the receiver stalls, a finished result waits in the publish state
//   until the output register frees, and no further item is taken.
// After reset the core clears every word of main memory, one word per cycle,
//   with in_ready low; registers and io state clear at once.
module simple_risc_core_step_unit #(
	parameter int MEM_WORDS = srcs_pkg::MEM_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [11:0] address,
	input  logic [31:0] data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] step_pc,
	output logic [31:0] step_instruction,
	output logic        halted,
	output logic        irq_taken,
	output logic [1:0]  io_access,
	output logic [4:0]  io_index,
	output logic [31:0] io_value,
	output logic [31:0] cycle_count,
	output logic [31:0] read_word
);

	srcs_pkg::cmd_t cmd;
	srcs_pkg::sts_t sts;

	// sequencing of each item
	srcs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .mode(mode), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	// storage and execution
	srcs_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.mode(mode), .address(address), .data(data),
		.step_pc(step_pc), .step_instruction(step_instruction),
		.halted(halted), .irq_taken(irq_taken),
		.io_access(io_access), .io_index(io_index), .io_value(io_value),
		.cycle_count(cycle_count), .read_word(read_word)
	);

endmodule
